// ===== hw/rtl/frfr_pkg.sv =====
package frfr_pkg;

	// Table size and derived widths
	localparam int unsigned ENTRIES = 16;
	localparam int unsigned IDX_W   = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
	localparam int unsigned CNT_W   = $clog2(ENTRIES + 1);
	localparam int unsigned FRAME_W = 31;

	typedef logic [FRAME_W-1:0] frame_t;
	typedef logic [CNT_W-1:0]   cnt_t;

	typedef enum logic [1:0] {
		KIND_CLEAR = 2'd0,
		KIND_LOAD  = 2'd1,
		KIND_MAP   = 2'd2,
		KIND_NONE  = 2'd3
	} kind_t;

	typedef enum logic [1:0] {
		STAT_OK      = 2'd0,
		STAT_BOUNDS  = 2'd1,
		STAT_OVERLAP = 2'd2,
		STAT_FULL    = 2'd3
	} status_t;

	// One range entry as written into a cell
	typedef struct packed {
		frame_t lo;
		frame_t hi;
		frame_t rep;
	} entry_t;

	// Per-cell control from the top level
	typedef struct packed {
		logic active;
		logic wr_en;
	} cell_ctl_t;

	// Transaction record handed from cell to cell
	typedef struct packed {
		logic   valid;
		kind_t  kind;
		frame_t lo;
		frame_t hi;
		frame_t key;
		logic   hit;
		frame_t src;
		logic   ovl;
	} carry_t;

endpackage

// ===== hw/rtl/frfr_req_if.sv =====
interface frfr_req_if;
	logic            valid;
	logic            ready;
	logic [1:0]      kind;
	frfr_pkg::frame_t frame_number;
	frfr_pkg::frame_t range_first;
	frfr_pkg::frame_t range_last;
	frfr_pkg::frame_t replacement;

	modport source (output valid, kind, frame_number, range_first, range_last, replacement,
		input ready);
	modport sink (input valid, kind, frame_number, range_first, range_last, replacement,
		output ready);
endinterface

// ===== hw/rtl/frfr_rsp_if.sv =====
interface frfr_rsp_if;
	logic             valid;
	logic             ready;
	logic [1:0]       status;
	frfr_pkg::frame_t source_frame;
	logic             frozen;

	modport source (output valid, status, source_frame, frozen, input ready);
	modport sink (input valid, status, source_frame, frozen, output ready);
endinterface

// ===== hw/rtl/frfr_cfg_if.sv =====
interface frfr_cfg_if;
	logic             valid;
	logic             ready;
	frfr_pkg::frame_t clip_length;

	modport source (output valid, clip_length, input ready);
	modport sink (input valid, clip_length, output ready);
endinterface

// ===== hw/rtl/freeze_range_frame_remap_top.sv =====
// Frame range freeze remapper. Keeps up to ENTRIES frame ranges, each with a replacement
// frame, in a row of cells; a request clears the table, loads a range or maps a frame,
// and every request returns exactly one response. One request is in flight at a time:
// it passes a head stage and then walks the cell row one cell per cycle. Its response
// is registered after the record leaves the last cell, once the output register is
// free, and the request port is ready again in the same cycle. A response waiting at
// the output does not stop the next request from being accepted and walked. clip_length
// may only be written while no request is pending; zero disables the bound check on loads.
module freeze_range_frame_remap_top (
	input  logic clk,
	input  logic arst_n,
	frfr_req_if.sink   req,
	frfr_rsp_if.source rsp,
	frfr_cfg_if.sink   cfg
);

	typedef enum logic [2:0] {
		S_IDLE = 3'b001,
		S_WALK = 3'b010,
		S_DONE = 3'b100
	} state_t;

	state_t                   state_q;
	frfr_pkg::frame_t         clip_q;
	frfr_pkg::cnt_t           cnt_q;
	frfr_pkg::carry_t         head_q;
	logic                     head_valid_q;
	frfr_pkg::carry_t         res_q;
	frfr_pkg::carry_t         chain [frfr_pkg::ENTRIES+1];
	frfr_pkg::cell_ctl_t      ctl [frfr_pkg::ENTRIES];
	frfr_pkg::entry_t         wr_ent;
	logic                     accept;
	logic                     commit;
	logic                     load_ok;
	frfr_pkg::status_t        status_d;
	logic                     rsp_valid_q;
	logic [1:0]               rsp_status_q;
	frfr_pkg::frame_t         rsp_src_q;
	logic                     rsp_frozen_q;

	assign accept    = req.valid && req.ready;
	assign req.ready = (state_q == S_IDLE);
	assign cfg.ready = 1'b1;

	// Configuration register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clip_q <= '0;
		end else if (cfg.valid) begin
			clip_q <= cfg.clip_length;
		end
	end

	// Head stage: order the range ends and seed the record
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_valid_q <= 1'b0;
		end else begin
			head_valid_q <= accept;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			head_q.valid <= 1'b1;
			head_q.kind <= frfr_pkg::kind_t'(req.kind);
			if (req.range_first > req.range_last) begin
				head_q.lo <= req.range_last;
				head_q.hi <= req.range_first;
			end else begin
				head_q.lo <= req.range_first;
				head_q.hi <= req.range_last;
			end
			head_q.key <= (req.kind == frfr_pkg::KIND_MAP) ? req.frame_number : req.replacement;
			head_q.src <= req.frame_number;
			head_q.hit <= 1'b0;
			head_q.ovl <= 1'b0;
		end
	end

	always_comb begin
		chain[0]       = head_q;
		chain[0].valid = head_valid_q;
	end

	// Cell row
	assign wr_ent.lo  = res_q.lo;
	assign wr_ent.hi  = res_q.hi;
	assign wr_ent.rep = res_q.key;

	for (genvar i = 0; i < frfr_pkg::ENTRIES; i++) begin : g_cell
		always_comb begin
			ctl[i].active = (frfr_pkg::CNT_W'(i) < cnt_q);
			ctl[i].wr_en  = commit && load_ok
				&& (cnt_q[frfr_pkg::IDX_W-1:0] == frfr_pkg::IDX_W'(i));
		end

		frfr_cell u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.ctl       (ctl[i]),
			.wr        (wr_ent),
			.carry_in  (chain[i]),
			.carry_out (chain[i+1])
		);
	end

	// Capture the record leaving the last cell
	always_ff @(posedge clk) begin
		if (chain[frfr_pkg::ENTRIES].valid) begin
			res_q <= chain[frfr_pkg::ENTRIES];
		end
	end

	// Resolve load status: bounds, then overlap, then full
	always_comb begin
		status_d = frfr_pkg::STAT_OK;
		if (res_q.kind == frfr_pkg::KIND_LOAD) begin
			priority if (clip_q != '0 && (res_q.hi >= clip_q || res_q.key >= clip_q)) begin
				status_d = frfr_pkg::STAT_BOUNDS;
			end else if (res_q.ovl) begin
				status_d = frfr_pkg::STAT_OVERLAP;
			end else if (cnt_q >= frfr_pkg::CNT_W'(frfr_pkg::ENTRIES)) begin
				status_d = frfr_pkg::STAT_FULL;
			end else begin
				status_d = frfr_pkg::STAT_OK;
			end
		end
	end

	assign commit  = (state_q == S_DONE) && (!rsp_valid_q || rsp.ready);
	assign load_ok = (res_q.kind == frfr_pkg::KIND_LOAD) && (status_d == frfr_pkg::STAT_OK);

	// Sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (accept) state_q <= S_WALK;
				end
				S_WALK: begin
					if (chain[frfr_pkg::ENTRIES].valid) state_q <= S_DONE;
				end
				S_DONE: begin
					if (commit) state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// Table fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (commit) begin
			if (res_q.kind == frfr_pkg::KIND_CLEAR) begin
				cnt_q <= '0;
			end else if (load_ok) begin
				cnt_q <= cnt_q + frfr_pkg::CNT_W'(1);
			end
		end
	end

	// Response register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (commit) begin
			rsp_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (commit) begin
			rsp_status_q <= status_d;
			rsp_src_q    <= (res_q.kind == frfr_pkg::KIND_MAP) ? res_q.src : '0;
			rsp_frozen_q <= (res_q.kind == frfr_pkg::KIND_MAP) && res_q.hit;
		end
	end

	assign rsp.valid        = rsp_valid_q;
	assign rsp.status       = rsp_status_q;
	assign rsp.source_frame = rsp_src_q;
	assign rsp.frozen       = rsp_frozen_q;

	// Checks
	logic [frfr_pkg::ENTRIES:0] chain_vld;
	for (genvar j = 0; j <= frfr_pkg::ENTRIES; j++) begin : g_vld
		assign chain_vld[j] = chain[j].valid;
	end

	a_cnt_range: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= frfr_pkg::CNT_W'(frfr_pkg::ENTRIES))
		else $error("entry count beyond table size");

	a_one_in_flight: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0(chain_vld))
		else $error("more than one transaction in the cell row");

	a_commit_rsp: assert property (@(posedge clk) disable iff (!arst_n)
		commit |=> rsp_valid_q)
		else $error("committed response not presented");

	a_walk_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(chain_vld != '0) |-> (state_q == S_WALK))
		else $error("transaction in cell row outside walk");

endmodule

// ===== hw/rtl/frfr_cell.sv =====
module frfr_cell (
	input  logic                clk,
	input  logic                arst_n,
	input  frfr_pkg::cell_ctl_t ctl,
	input  frfr_pkg::entry_t    wr,
	input  frfr_pkg::carry_t    carry_in,
	output frfr_pkg::carry_t    carry_out
);

	frfr_pkg::entry_t ent_q;
	frfr_pkg::carry_t nxt;
	frfr_pkg::carry_t carry_q;
	logic             valid_q;

	// Hold the stored range
	always_ff @(posedge clk) begin
		if (ctl.wr_en) begin
			ent_q <= wr;
		end
	end

	// Check the passing transaction against this entry
	always_comb begin
		nxt = carry_in;
		if (carry_in.valid && ctl.active) begin
			if (carry_in.kind == frfr_pkg::KIND_MAP && !carry_in.hit
					&& carry_in.key >= ent_q.lo && carry_in.key <= ent_q.hi) begin
				nxt.hit = 1'b1;
				nxt.src = ent_q.rep;
			end
			if (carry_in.kind == frfr_pkg::KIND_LOAD
					&& carry_in.lo <= ent_q.hi && ent_q.lo <= carry_in.hi) begin
				nxt.ovl = 1'b1;
			end
		end
	end

	// Advance to the neighbor
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else begin
			valid_q <= carry_in.valid;
		end
	end

	always_ff @(posedge clk) begin
		carry_q <= nxt;
	end

	always_comb begin
		carry_out       = carry_q;
		carry_out.valid = valid_q;
	end

endmodule

// ===== tb/tb_freeze_range_frame_remap_top.sv =====
`timescale 1ns / 100ps

module tb_freeze_range_frame_remap_top;

	localparam frfr_pkg::frame_t FRAME_MAX = '1;

	typedef struct {
		frfr_pkg::kind_t  kind;
		frfr_pkg::frame_t frame_number;
		frfr_pkg::frame_t range_first;
		frfr_pkg::frame_t range_last;
		frfr_pkg::frame_t replacement;
	} remap_req_t;

	typedef struct {
		frfr_pkg::status_t status;
		frfr_pkg::frame_t  source_frame;
		logic              frozen;
	} remap_rsp_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	frfr_req_if req_if ();
	frfr_rsp_if rsp_if ();
	frfr_cfg_if cfg_if ();

	freeze_range_frame_remap_top u_top (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_if),
		.rsp    (rsp_if),
		.cfg    (cfg_if)
	);

	always #5 clk = ~clk;

	// Shadow of the range table and the clip length register
	frfr_pkg::frame_t tbl_lo [frfr_pkg::ENTRIES];
	frfr_pkg::frame_t tbl_hi [frfr_pkg::ENTRIES];
	frfr_pkg::frame_t tbl_rep [frfr_pkg::ENTRIES];
	int unsigned      tbl_count = 0;
	frfr_pkg::frame_t clip_reg = '0;

	remap_req_t       pending_reqs [$];
	remap_rsp_t       expected_rsps [$];
	frfr_pkg::frame_t bound_frames [$];
	int unsigned      mismatch_count = 0;

	// Apply one request to the shadow table and return its response
	function automatic remap_rsp_t remap_answer(remap_req_t r);
		remap_rsp_t a;
		frfr_pkg::frame_t lo;
		frfr_pkg::frame_t hi;
		logic ovl;
		a.status = frfr_pkg::STAT_OK;
		a.source_frame = '0;
		a.frozen = 1'b0;
		case (r.kind)
			frfr_pkg::KIND_CLEAR: begin
				tbl_count = 0;
			end
			frfr_pkg::KIND_LOAD: begin
				lo = r.range_first;
				hi = r.range_last;
				if (lo > hi) begin
					lo = r.range_last;
					hi = r.range_first;
				end
				ovl = 1'b0;
				for (int i = 0; i < tbl_count; i++)
					if (lo <= tbl_hi[i] && tbl_lo[i] <= hi)
						ovl = 1'b1;
				if (clip_reg != 0 && (hi >= clip_reg || r.replacement >= clip_reg)) begin
					a.status = frfr_pkg::STAT_BOUNDS;
				end else if (ovl) begin
					a.status = frfr_pkg::STAT_OVERLAP;
				end else if (tbl_count >= frfr_pkg::ENTRIES) begin
					a.status = frfr_pkg::STAT_FULL;
				end else begin
					tbl_lo[tbl_count] = lo;
					tbl_hi[tbl_count] = hi;
					tbl_rep[tbl_count] = r.replacement;
					tbl_count++;
				end
			end
			frfr_pkg::KIND_MAP: begin
				a.source_frame = r.frame_number;
				for (int i = 0; i < tbl_count; i++) begin
					if (!a.frozen && r.frame_number >= tbl_lo[i]
							&& r.frame_number <= tbl_hi[i]) begin
						a.source_frame = tbl_rep[i];
						a.frozen = 1'b1;
					end
				end
			end
			default: ;
		endcase
		return a;
	endfunction

	// Driver: bursts of requests with random gaps between them
	logic       drv_valid_next;
	remap_req_t drv_item;
	int         burst_left = 0;
	int         gap_left = 0;

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			req_if.valid <= 1'b0;
			burst_left = 0;
			gap_left = 0;
		end else begin
			drv_valid_next = req_if.valid;
			if (req_if.valid && req_if.ready) begin
				expected_rsps.push_back(remap_answer(drv_item));
				drv_valid_next = 1'b0;
			end
			if (!drv_valid_next) begin
				if (gap_left > 0) begin
					gap_left--;
				end else if (pending_reqs.size() > 0) begin
					drv_item = pending_reqs.pop_front();
					req_if.kind <= drv_item.kind;
					req_if.frame_number <= drv_item.frame_number;
					req_if.range_first <= drv_item.range_first;
					req_if.range_last <= drv_item.range_last;
					req_if.replacement <= drv_item.replacement;
					drv_valid_next = 1'b1;
					if (burst_left == 0)
						burst_left = $urandom_range(1, 12);
					burst_left--;
					if (burst_left == 0)
						gap_left = ($urandom_range(0, 3) == 0) ? $urandom_range(4, 30) :
							$urandom_range(0, 3);
				end
			end
			req_if.valid <= drv_valid_next;
		end
	end

	// Receiver: switch between four randomly chosen stall patterns
	int stall_mode = 0;
	int mode_left = 0;
	int stall_left = 0;

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_if.ready <= 1'b0;
			stall_mode = 0;
			mode_left = 0;
			stall_left = 0;
		end else begin
			if (mode_left == 0) begin
				stall_mode = $urandom_range(0, 3);
				mode_left = $urandom_range(32, 256);
			end else begin
				mode_left--;
			end
			case (stall_mode)
				0: rsp_if.ready <= 1'b1;
				1: rsp_if.ready <= ($urandom_range(0, 3) != 0);
				2: rsp_if.ready <= ($urandom_range(0, 9) < 3);
				default: begin
					if (stall_left > 0) begin
						stall_left--;
						rsp_if.ready <= 1'b0;
					end else begin
						if ($urandom_range(0, 15) == 0)
							stall_left = $urandom_range(5, 40);
						rsp_if.ready <= 1'b1;
					end
				end
			endcase
		end
	end

	// Monitor: compare each response transaction with the oldest expectation
	remap_rsp_t mon_exp;

	always @(posedge clk) begin
		if (arst_n && rsp_if.valid && rsp_if.ready) begin
			if (expected_rsps.size() == 0) begin
				mismatch_count++;
				if (mismatch_count <= 10)
					$display({"%0t: response with nothing expected: ",
						"status %0d source_frame %0d frozen %0d"},
						$realtime, rsp_if.status, rsp_if.source_frame, rsp_if.frozen);
			end else begin
				mon_exp = expected_rsps.pop_front();
				if (rsp_if.status !== mon_exp.status
						|| rsp_if.source_frame !== mon_exp.source_frame
						|| rsp_if.frozen !== mon_exp.frozen) begin
					mismatch_count++;
					if (mismatch_count <= 10)
						$display({"%0t: mismatch: status exp %0d got %0d, ",
							"source_frame exp %0d got %0d, frozen exp %0d got %0d"},
							$realtime, mon_exp.status, rsp_if.status, mon_exp.source_frame,
							rsp_if.source_frame, mon_exp.frozen, rsp_if.frozen);
				end
			end
		end
	end

	task automatic push_req(frfr_pkg::kind_t kind, frfr_pkg::frame_t frame_number,
			frfr_pkg::frame_t first, frfr_pkg::frame_t last,
			frfr_pkg::frame_t replacement);
		remap_req_t r;
		r.kind = kind;
		r.frame_number = frame_number;
		r.range_first = first;
		r.range_last = last;
		r.replacement = replacement;
		pending_reqs.push_back(r);
	endtask

	function automatic frfr_pkg::frame_t pick_frame(frfr_pkg::frame_t span);
		int unsigned sel;
		sel = $urandom_range(0, 31);
		if (sel == 0)
			return FRAME_MAX;
		if (sel < 3)
			return frfr_pkg::frame_t'($urandom);
		return frfr_pkg::frame_t'($urandom_range(0, span));
	endfunction

	function automatic frfr_pkg::frame_t near_bound();
		frfr_pkg::frame_t b;
		b = bound_frames[$urandom_range(0, bound_frames.size() - 1)];
		case ($urandom_range(0, 2))
			0: return (b == 0) ? b : frfr_pkg::frame_t'(b - 1);
			1: return b;
			default: return (b == FRAME_MAX) ? b : frfr_pkg::frame_t'(b + 1);
		endcase
	endfunction

	// Fill the pending queue: mostly load runs followed by maps, some clears and noise
	task automatic build_traffic(int n_items, frfr_pkg::frame_t span);
		int left;
		int n_loads;
		int n_maps;
		int unsigned len;
		logic [31:0] sum;
		frfr_pkg::frame_t lo;
		frfr_pkg::frame_t hi;
		frfr_pkg::frame_t rep;
		left = n_items;
		while (left > 0) begin
			case ($urandom_range(0, 99)) inside
				[0:7]: begin
					push_req(frfr_pkg::KIND_CLEAR, frfr_pkg::frame_t'($urandom),
						frfr_pkg::frame_t'($urandom), frfr_pkg::frame_t'($urandom),
						frfr_pkg::frame_t'($urandom));
					bound_frames.delete();
					left--;
				end
				[8:11]: begin
					push_req(frfr_pkg::kind_t'($urandom_range(0, 3)),
						frfr_pkg::frame_t'($urandom), frfr_pkg::frame_t'($urandom),
						frfr_pkg::frame_t'($urandom), frfr_pkg::frame_t'($urandom));
					left--;
				end
				default: begin
					n_loads = $urandom_range(1, 20);
					n_maps = $urandom_range(1, 10);
					for (int i = 0; i < n_loads && left > 0; i++) begin
						if (bound_frames.size() > 0 && $urandom_range(0, 4) == 0)
							lo = near_bound();
						else
							lo = pick_frame(span);
						len = $urandom_range(0, span / 16 + 1);
						sum = {1'b0, lo} + len;
						hi = (sum > FRAME_MAX) ? FRAME_MAX : frfr_pkg::frame_t'(sum);
						rep = pick_frame(span);
						if ($urandom_range(0, 3) == 0)
							push_req(frfr_pkg::KIND_LOAD, frfr_pkg::frame_t'($urandom),
								hi, lo, rep);
						else
							push_req(frfr_pkg::KIND_LOAD, frfr_pkg::frame_t'($urandom),
								lo, hi, rep);
						bound_frames.push_back(lo);
						bound_frames.push_back(hi);
						left--;
					end
					for (int i = 0; i < n_maps && left > 0; i++) begin
						if (bound_frames.size() > 0 && $urandom_range(0, 9) < 7)
							lo = near_bound();
						else
							lo = pick_frame(span);
						push_req(frfr_pkg::KIND_MAP, lo, frfr_pkg::frame_t'($urandom),
							frfr_pkg::frame_t'($urandom), frfr_pkg::frame_t'($urandom));
						left--;
					end
				end
			endcase
		end
	endtask

	// Hold until every queued request is accepted and every response has come
	task automatic drain();
		do
			@(negedge clk);
		while (pending_reqs.size() > 0 || req_if.valid || expected_rsps.size() > 0);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_clip_length(frfr_pkg::frame_t value);
		@(posedge clk);
		cfg_if.valid <= 1'b1;
		cfg_if.clip_length <= value;
		do
			@(posedge clk);
		while (!(cfg_if.valid && cfg_if.ready));
		clip_reg = value;
		cfg_if.valid <= 1'b0;
	endtask

	task automatic run_phase(frfr_pkg::frame_t clip, frfr_pkg::frame_t span, int n_items);
		drain();
		write_clip_length(clip);
		build_traffic(n_items, span);
	endtask

	// End the run if it hangs
	initial begin
		#(10_000_000);
		$display("tb_freeze_range_frame_remap_top: done, errors");
		$finish;
	end

	initial begin
		req_if.valid = 1'b0;
		req_if.kind = frfr_pkg::KIND_CLEAR;
		req_if.frame_number = '0;
		req_if.range_first = '0;
		req_if.range_last = '0;
		req_if.replacement = '0;
		rsp_if.ready = 1'b0;
		cfg_if.valid = 1'b0;
		cfg_if.clip_length = '0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;

		// Directed: empty table, reversed ends, touching and nested ranges, extremes, unused kind
		push_req(frfr_pkg::KIND_MAP, 31'd5, '0, '0, '0);
		push_req(frfr_pkg::KIND_MAP, FRAME_MAX, '0, '0, '0);
		push_req(frfr_pkg::KIND_CLEAR, '0, '0, '0, '0);
		push_req(frfr_pkg::KIND_LOAD, '0, 31'd10, 31'd20, 31'd100);
		push_req(frfr_pkg::KIND_LOAD, '0, 31'd40, 31'd30, 31'd7);
		push_req(frfr_pkg::KIND_LOAD, '0, 31'd20, 31'd25, 31'd1);
		push_req(frfr_pkg::KIND_LOAD, '0, 31'd12, 31'd13, 31'd2);
		push_req(frfr_pkg::KIND_MAP, 31'd10, '0, '0, '0);
		push_req(frfr_pkg::KIND_MAP, 31'd20, '0, '0, '0);
		push_req(frfr_pkg::KIND_MAP, 31'd21, '0, '0, '0);
		push_req(frfr_pkg::KIND_MAP, 31'd35, '0, '0, '0);
		push_req(frfr_pkg::KIND_MAP, 31'd9, '0, '0, '0);
		push_req(frfr_pkg::KIND_LOAD, '0, FRAME_MAX, FRAME_MAX, FRAME_MAX);
		push_req(frfr_pkg::KIND_MAP, FRAME_MAX, '0, '0, '0);
		push_req(frfr_pkg::KIND_NONE, FRAME_MAX, FRAME_MAX, FRAME_MAX, FRAME_MAX);
		drain();

		// Directed: bound checks, including a bound fault that also overlaps
		write_clip_length(31'd64);
		push_req(frfr_pkg::KIND_LOAD, '0, 31'd50, 31'd60, 31'd64);
		push_req(frfr_pkg::KIND_LOAD, '0, 31'd64, 31'd0, 31'd1);
		push_req(frfr_pkg::KIND_LOAD, '0, 31'd63, 31'd10, 31'd70);
		push_req(frfr_pkg::KIND_LOAD, '0, 31'd62, 31'd63, 31'd63);
		push_req(frfr_pkg::KIND_MAP, 31'd63, '0, '0, '0);

		// Random phases over a spread of clip lengths
		run_phase(31'd1, 31'd4, 220);
		run_phase(FRAME_MAX, 31'd1_000_000, 230);
		run_phase(31'd5000, 31'd6000, 230);
		run_phase(31'd0, 31'd300, 230);
		run_phase(31'd200, 31'd250, 220);
		run_phase(frfr_pkg::frame_t'($urandom_range(1, 32'h7FFF_FFFF)), 31'd100_000, 220);
		run_phase(31'd0, 31'd50_000, 230);
		drain();
		repeat (60) @(posedge clk);

		if (mismatch_count == 0)
			$display("tb_freeze_range_frame_remap_top: done, clean");
		else
			$display("tb_freeze_range_frame_remap_top: done, errors");
		$finish;
	end

endmodule
